// ===== src/sric_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sric_pkg
// shared types, corner and edge codes and result codes for the segment
// against rectangle boundary contact pipeline
// ----------------------------------------------------------------------------
package sric_pkg;

	localparam int IN_BITS    = 32;
	localparam int COUNT_BITS = 3;
	localparam int NUM_EDGES  = 4;
	localparam int NUM_CRN    = 4;

	// rectangle corners
	localparam logic [1:0] CRN_LL = 2'd0;
	localparam logic [1:0] CRN_LR = 2'd1;
	localparam logic [1:0] CRN_UR = 2'd2;
	localparam logic [1:0] CRN_UL = 2'd3;

	// rectangle edges
	localparam logic [1:0] EDGE_BOTTOM = 2'd0;
	localparam logic [1:0] EDGE_RIGHT  = 2'd1;
	localparam logic [1:0] EDGE_TOP    = 2'd2;
	localparam logic [1:0] EDGE_LEFT   = 2'd3;

	// result codes
	localparam logic [COUNT_BITS-1:0] TOUCH_NONE = 3'd0;
	localparam logic [COUNT_BITS-1:0] TOUCH_INF  = 3'd4;

	// compare results gathered in the first stage, one bit per edge plus the on_edge bit
	typedef struct packed {
		logic [NUM_EDGES-1:0] cd_zero;  // a segment endpoint lies on the edge line or the edge itself is degenerate
		logic [NUM_EDGES-1:0] cd_le0;   // segment endpoints not strictly on one side of edge line
		logic [NUM_EDGES-1:0] overlap;  // collinear overlap of sorted spans
		logic                 on_edge;  // segment lies along an edge line with open overlap
	} sric_flags_t;

	// sign of the segment orientation at each corner
	typedef struct packed {
		logic [NUM_CRN-1:0] neg;
		logic [NUM_CRN-1:0] zero;
	} sric_orient_t;

	// first end of an edge
	function automatic logic [1:0] edge_crn_a(input logic [1:0] edge_idx);
		logic [1:0] crn;
		unique case (edge_idx)
			EDGE_BOTTOM: crn = CRN_LL;
			EDGE_RIGHT:  crn = CRN_UR;
			EDGE_TOP:    crn = CRN_UL;
			EDGE_LEFT:   crn = CRN_UL;
			default:     crn = CRN_LL;
		endcase
		return crn;
	endfunction

	// second end of an edge
	function automatic logic [1:0] edge_crn_b(input logic [1:0] edge_idx);
		logic [1:0] crn;
		unique case (edge_idx)
			EDGE_BOTTOM: crn = CRN_LR;
			EDGE_RIGHT:  crn = CRN_LR;
			EDGE_TOP:    crn = CRN_UR;
			EDGE_LEFT:   crn = CRN_LL;
			default:     crn = CRN_LR;
		endcase
		return crn;
	endfunction

endpackage

// ===== src/segment_rectangle_intersection_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_rectangle_intersection_count
// counts the points a line segment shares with the boundary of an
// axis-aligned rectangle
// ----------------------------------------------------------------------------
// The block takes one request per clock while in_stall is low and returns
// one touch_count per request, in order. The pipeline has four registers:
// coordinate differences and edge compares, the cross-product multipliers,
// the exact orientation compares, and the final count register that drives
// the output. touch_count is 0 when the segment misses the boundary, 1 or 2
// for that many shared points, and 4 when the segment runs along an edge
// over an open stretch (infinitely many points). Only the low COORD_BITS
// bits of each coordinate are used, sign-extended. A stall on the output
// holds the whole pipeline; empty stages still fill, so the input keeps
// taking requests until every stage holds one.
// ----------------------------------------------------------------------------
module segment_rectangle_intersection_count #(
	parameter int COORD_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [sric_pkg::IN_BITS-1:0]   rect_left,
	input  logic signed [sric_pkg::IN_BITS-1:0]   rect_bottom,
	input  logic signed [sric_pkg::IN_BITS-1:0]   rect_right,
	input  logic signed [sric_pkg::IN_BITS-1:0]   rect_top,
	input  logic signed [sric_pkg::IN_BITS-1:0]   seg_x1,
	input  logic signed [sric_pkg::IN_BITS-1:0]   seg_y1,
	input  logic signed [sric_pkg::IN_BITS-1:0]   seg_x2,
	input  logic signed [sric_pkg::IN_BITS-1:0]   seg_y2,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [sric_pkg::COUNT_BITS-1:0]       touch_count
);

	import sric_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	// stage valid bits and per-stage load enables
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	// stage one outputs
	logic signed [DW-1:0] dx_s1, dy_s1, ex_s1, gx_s1, fy_s1, hy_s1;
	sric_flags_t          flags_s1;

	// stage two outputs
	logic signed [PW-1:0] dx_fy_s2, dx_hy_s2, dy_ex_s2, dy_gx_s2;
	sric_flags_t          flags_s2;

	// stage three outputs
	sric_orient_t         orient_s3;
	sric_flags_t          flags_s3;

	// a stage loads when it is empty or its content moves on
	assign en4 = !valid_s4 || !out_stall;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign in_stall  = !en1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// differences and compares
	sric_prep #(
		.COORD_BITS (COORD_BITS)
	) u_prep (
		.clk         (clk),
		.en          (en1),
		.rect_left   (rect_left),
		.rect_bottom (rect_bottom),
		.rect_right  (rect_right),
		.rect_top    (rect_top),
		.seg_x1      (seg_x1),
		.seg_y1      (seg_y1),
		.seg_x2      (seg_x2),
		.seg_y2      (seg_y2),
		.dx_s1       (dx_s1),
		.dy_s1       (dy_s1),
		.ex_s1       (ex_s1),
		.gx_s1       (gx_s1),
		.fy_s1       (fy_s1),
		.hy_s1       (hy_s1),
		.flags_s1    (flags_s1)
	);

	// cross-product terms
	sric_mult #(
		.COORD_BITS (COORD_BITS)
	) u_mult (
		.clk      (clk),
		.en       (en2),
		.dx_s1    (dx_s1),
		.dy_s1    (dy_s1),
		.ex_s1    (ex_s1),
		.gx_s1    (gx_s1),
		.fy_s1    (fy_s1),
		.hy_s1    (hy_s1),
		.flags_s1 (flags_s1),
		.dx_fy_s2 (dx_fy_s2),
		.dx_hy_s2 (dx_hy_s2),
		.dy_ex_s2 (dy_ex_s2),
		.dy_gx_s2 (dy_gx_s2),
		.flags_s2 (flags_s2)
	);

	// corner orientation signs
	sric_orient #(
		.COORD_BITS (COORD_BITS)
	) u_orient (
		.clk       (clk),
		.en        (en3),
		.dx_fy_s2  (dx_fy_s2),
		.dx_hy_s2  (dx_hy_s2),
		.dy_ex_s2  (dy_ex_s2),
		.dy_gx_s2  (dy_gx_s2),
		.flags_s2  (flags_s2),
		.orient_s3 (orient_s3),
		.flags_s3  (flags_s3)
	);

	// final count, doubles as the output register
	sric_count u_count (
		.clk            (clk),
		.en             (en4),
		.orient_s3      (orient_s3),
		.flags_s3       (flags_s3),
		.touch_count_s4 (touch_count)
	);

	// an accepted request always lands in the first stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted request did not reach stage one");

	// an empty first stage never pushes back on the input
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with stage one empty");

	// a held stage only happens behind a full downstream stage
	a_hold_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en1 |-> valid_s2 && valid_s3 && valid_s4 && out_stall)
		else $error("stage one held without a full pipeline behind it");

	// the count never exceeds four, which codes an edge overlap
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> touch_count <= TOUCH_INF)
		else $error("touch count out of range");

endmodule

// ===== src/sric_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sric_prep
// stage one: coordinate differences for the orientation products and all
// plain coordinate compares against the axis-aligned edges
// ----------------------------------------------------------------------------
module sric_prep #(
	parameter int COORD_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [sric_pkg::IN_BITS-1:0]   rect_left,
	input  logic signed [sric_pkg::IN_BITS-1:0]   rect_bottom,
	input  logic signed [sric_pkg::IN_BITS-1:0]   rect_right,
	input  logic signed [sric_pkg::IN_BITS-1:0]   rect_top,
	input  logic signed [sric_pkg::IN_BITS-1:0]   seg_x1,
	input  logic signed [sric_pkg::IN_BITS-1:0]   seg_y1,
	input  logic signed [sric_pkg::IN_BITS-1:0]   seg_x2,
	input  logic signed [sric_pkg::IN_BITS-1:0]   seg_y2,
	output logic signed [COORD_BITS:0]            dx_s1,
	output logic signed [COORD_BITS:0]            dy_s1,
	output logic signed [COORD_BITS:0]            ex_s1,
	output logic signed [COORD_BITS:0]            gx_s1,
	output logic signed [COORD_BITS:0]            fy_s1,
	output logic signed [COORD_BITS:0]            hy_s1,
	output sric_pkg::sric_flags_t                 flags_s1
);

	import sric_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int DW = COORD_BITS + 1;

	logic signed [CW-1:0] rl, rb, rr, rt, x1, y1, x2, y2;
	logic signed [CW-1:0] cx [NUM_CRN];
	logic signed [CW-1:0] cy [NUM_CRN];
	logic signed [CW-1:0] px [2];
	logic signed [CW-1:0] py [2];
	logic [1:0]           c_le_p [NUM_CRN];
	logic [1:0]           p_le_c [NUM_CRN];
	logic                 vert, horz;
	sric_flags_t          flags;

	// only the low coordinate bits count, sign-extended
	assign rl = $signed(rect_left[CW-1:0]);
	assign rb = $signed(rect_bottom[CW-1:0]);
	assign rr = $signed(rect_right[CW-1:0]);
	assign rt = $signed(rect_top[CW-1:0]);
	assign x1 = $signed(seg_x1[CW-1:0]);
	assign y1 = $signed(seg_y1[CW-1:0]);
	assign x2 = $signed(seg_x2[CW-1:0]);
	assign y2 = $signed(seg_y2[CW-1:0]);

	always_comb begin
		cx[CRN_LL] = rl; cy[CRN_LL] = rb;
		cx[CRN_LR] = rr; cy[CRN_LR] = rb;
		cx[CRN_UR] = rr; cy[CRN_UR] = rt;
		cx[CRN_UL] = rl; cy[CRN_UL] = rt;
		px[0] = x1; py[0] = y1;
		px[1] = x2; py[1] = y2;
	end

	// lexicographic order between every corner and every segment end
	always_comb begin
		for (int k = 0; k < NUM_CRN; k++) begin
			for (int j = 0; j < 2; j++) begin
				c_le_p[k][j] = (cx[k] < px[j]) || (cx[k] == px[j] && cy[k] <= py[j]);
				p_le_c[k][j] = (px[j] < cx[k]) || (px[j] == cx[k] && py[j] <= cy[k]);
			end
		end
	end

	always_comb begin
		// side of each edge line for both segment ends
		flags.cd_zero[EDGE_BOTTOM] = (rr == rl) || (y1 == rb) || (y2 == rb);
		flags.cd_le0[EDGE_BOTTOM]  = flags.cd_zero[EDGE_BOTTOM] || ((y1 < rb) ^ (y2 < rb));
		flags.cd_zero[EDGE_RIGHT]  = (rt == rb) || (x1 == rr) || (x2 == rr);
		flags.cd_le0[EDGE_RIGHT]   = flags.cd_zero[EDGE_RIGHT] || ((x1 < rr) ^ (x2 < rr));
		flags.cd_zero[EDGE_TOP]    = (rr == rl) || (y1 == rt) || (y2 == rt);
		flags.cd_le0[EDGE_TOP]     = flags.cd_zero[EDGE_TOP] || ((y1 < rt) ^ (y2 < rt));
		flags.cd_zero[EDGE_LEFT]   = (rt == rb) || (x1 == rl) || (x2 == rl);
		flags.cd_le0[EDGE_LEFT]    = flags.cd_zero[EDGE_LEFT] || ((x1 < rl) ^ (x2 < rl));

		// min of one span below max of the other, both ways
		for (int i = 0; i < NUM_EDGES; i++) begin
			flags.overlap[i] =
				((|c_le_p[edge_crn_a(2'(i))]) || (|c_le_p[edge_crn_b(2'(i))])) &&
				((|p_le_c[edge_crn_a(2'(i))]) || (|p_le_c[edge_crn_b(2'(i))]));
		end

		// segment along an edge line, vertical lines checked first
		vert = (x1 == x2) && ((x1 == rl) || (x1 == rr));
		horz = (y1 == y2) && ((y1 == rb) || (y1 == rt));
		priority if (vert) begin
			flags.on_edge = (y1 < rt && y2 > rb) || (y2 < rt && y1 > rb);
		end else if (horz) begin
			flags.on_edge = (x1 < rr && x2 > rl) || (x2 < rr && x1 > rl);
		end else begin
			flags.on_edge = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= DW'(x2) - DW'(x1);
			dy_s1    <= DW'(y2) - DW'(y1);
			ex_s1    <= DW'(rl) - DW'(x1);
			gx_s1    <= DW'(rr) - DW'(x1);
			fy_s1    <= DW'(rb) - DW'(y1);
			hy_s1    <= DW'(rt) - DW'(y1);
			flags_s1 <= flags;
		end
	end

endmodule

// ===== src/sric_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sric_mult
// stage two: the four cross-product terms shared by the corner orientations
// ----------------------------------------------------------------------------
module sric_mult #(
	parameter int COORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_BITS:0]    dx_s1,
	input  logic signed [COORD_BITS:0]    dy_s1,
	input  logic signed [COORD_BITS:0]    ex_s1,
	input  logic signed [COORD_BITS:0]    gx_s1,
	input  logic signed [COORD_BITS:0]    fy_s1,
	input  logic signed [COORD_BITS:0]    hy_s1,
	input  sric_pkg::sric_flags_t         flags_s1,
	output logic signed [2*COORD_BITS+1:0] dx_fy_s2,
	output logic signed [2*COORD_BITS+1:0] dx_hy_s2,
	output logic signed [2*COORD_BITS+1:0] dy_ex_s2,
	output logic signed [2*COORD_BITS+1:0] dy_gx_s2,
	output sric_pkg::sric_flags_t         flags_s2
);

	import sric_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_fy_s2 <= dx_s1 * fy_s1;
			dx_hy_s2 <= dx_s1 * hy_s1;
			dy_ex_s2 <= dy_s1 * ex_s1;
			dy_gx_s2 <= dy_s1 * gx_s1;
			flags_s2 <= flags_s1;
		end
	end

endmodule

// ===== src/sric_orient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sric_orient
// stage three: exact sign of the segment orientation at each rectangle corner
// ----------------------------------------------------------------------------
module sric_orient #(
	parameter int COORD_BITS = 32
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [2*COORD_BITS+1:0] dx_fy_s2,
	input  logic signed [2*COORD_BITS+1:0] dx_hy_s2,
	input  logic signed [2*COORD_BITS+1:0] dy_ex_s2,
	input  logic signed [2*COORD_BITS+1:0] dy_gx_s2,
	input  sric_pkg::sric_flags_t          flags_s2,
	output sric_pkg::sric_orient_t         orient_s3,
	output sric_pkg::sric_flags_t          flags_s3
);

	import sric_pkg::*;

	sric_orient_t orient;

	// orientation is dx*(cy-y1) - dy*(cx-x1); its sign is a signed compare
	always_comb begin
		orient.neg[CRN_LL]  = dx_fy_s2 < dy_ex_s2;
		orient.zero[CRN_LL] = dx_fy_s2 == dy_ex_s2;
		orient.neg[CRN_LR]  = dx_fy_s2 < dy_gx_s2;
		orient.zero[CRN_LR] = dx_fy_s2 == dy_gx_s2;
		orient.neg[CRN_UR]  = dx_hy_s2 < dy_gx_s2;
		orient.zero[CRN_UR] = dx_hy_s2 == dy_gx_s2;
		orient.neg[CRN_UL]  = dx_hy_s2 < dy_ex_s2;
		orient.zero[CRN_UL] = dx_hy_s2 == dy_ex_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			orient_s3 <= orient;
			flags_s3  <= flags_s2;
		end
	end

endmodule

// ===== src/sric_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sric_count
// stage four: per-edge hit, crossing and corner contact decisions and the
// final boundary contact count
// ----------------------------------------------------------------------------
module sric_count (
	input  logic                                  clk,
	input  logic                                  en,
	input  sric_pkg::sric_orient_t                orient_s3,
	input  sric_pkg::sric_flags_t                 flags_s3,
	output logic [sric_pkg::COUNT_BITS-1:0]       touch_count_s4
);

	import sric_pkg::*;

	logic [NUM_EDGES-1:0]  ab_zero, ab_neg, meets, contact, crossing;
	logic [COUNT_BITS-1:0] n_contact, n_cross, count, touch;

	always_comb begin
		for (int i = 0; i < NUM_EDGES; i++) begin
			// sign product of the orientations at both edge ends
			ab_zero[i] = orient_s3.zero[edge_crn_a(2'(i))] ||
				orient_s3.zero[edge_crn_b(2'(i))];
			ab_neg[i]  = !ab_zero[i] &&
				(orient_s3.neg[edge_crn_a(2'(i))] ^ orient_s3.neg[edge_crn_b(2'(i))]);
			if (ab_zero[i] && flags_s3.cd_zero[i]) begin
				meets[i] = flags_s3.overlap[i];
			end else begin
				meets[i] = (ab_zero[i] || ab_neg[i]) && flags_s3.cd_le0[i];
			end
			contact[i]  = ab_zero[i] && flags_s3.cd_le0[i];
			crossing[i] = ab_neg[i] && flags_s3.cd_le0[i];
		end
		n_contact = COUNT_BITS'($countones(contact));
		n_cross   = COUNT_BITS'($countones(crossing));
		count     = n_cross + (n_contact >> 1);
		priority if (!(|meets)) begin
			touch = TOUCH_NONE;
		end else if (flags_s3.on_edge) begin
			touch = TOUCH_INF;
		end else begin
			touch = count;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			touch_count_s4 <= touch;
		end
	end

endmodule
